### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

### src/smr_pkg.sv
// ----------------------------------------------------------------------------
// Spiral matrix readout package
// Widths, types and register indexes shared by the spiral readout RTL.
// ----------------------------------------------------------------------------
package smr_pkg;

  localparam int ELEM_W    = 32;
  localparam int SIZE_W    = 4;
  localparam int COUNT_W   = 7;
  localparam int TOTAL_W   = 8;
  localparam int CFG_IDX_W = 2;

  typedef logic [ELEM_W-1:0]    elem_t;
  typedef logic [SIZE_W-1:0]    size_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [TOTAL_W-1:0]   total_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_ROW_COUNT    = 2'd0;
  localparam cfg_idx_t REG_COLUMN_COUNT = 2'd1;

  localparam size_t SIZE_RESET = 4'd8;

endpackage

### src/spiral_matrix_readout.sv
// ----------------------------------------------------------------------------
// Spiral matrix readout
// Loads a matrix in row-major order and reads it back in clockwise spiral order.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle while the block is loading. The transfer
// that completes the matrix starts the spiral walk: a small sequencer steps
// one row/column position per issued read of the element RAM. Read data passes
// through the RAM read register and then the output register, and a new read
// is issued only when no read is pending and the output register is free or
// being taken, so reads do not overlap. No element is taken during the walk.
// After a register write the load position is recomputed by a bit-serial
// divider, and while it runs neither elements nor register writes are taken.
// The last result of each spiral carries final_flag_o. Sizes of 0 act as 1
// and sizes above the maximum act as the maximum.
module spiral_matrix_readout #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Element input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [smr_pkg::ELEM_W-1:0]   element_value_i,
  // Spiral output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [smr_pkg::ELEM_W-1:0]   spiral_value_o,
  output logic                                final_flag_o,
  // Register writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [smr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [smr_pkg::SIZE_W-1:0]          cfg_data_i
);

  `include "assert_macros.svh"

  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int DivCntW = $clog2(smr_pkg::COUNT_W);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(smr_pkg::COUNT_W - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPrep = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StWalk = 2'd3;

  localparam logic [1:0] DirRight = 2'd0;
  localparam logic [1:0] DirDown  = 2'd1;
  localparam logic [1:0] DirLeft  = 2'd2;
  localparam logic [1:0] DirUp    = 2'd3;

  logic [1:0]       state_q, state_d;
  smr_pkg::size_t   row_count_q, column_count_q;
  smr_pkg::size_t   rows_eff, cols_eff;
  smr_pkg::total_t  total, last_pos, pos, pos_inc;
  smr_pkg::count_t  load_count_q, load_count_d, count_next;
  smr_pkg::size_t   load_row_q, load_row_d, load_col_q, load_col_d;
  logic             in_accept, cfg_accept, out_accept, completes;

  logic [DivCntW-1:0]           div_cnt_q;
  logic [smr_pkg::COUNT_W-1:0]  div_dvd_q, div_dvd_next;
  smr_pkg::size_t               div_rem_q, div_rem_next;
  logic [smr_pkg::SIZE_W:0]     rem_sh, rem_sub;
  logic                         rem_ge;

  smr_pkg::size_t   walk_row_q, walk_row_d, walk_col_q, walk_col_d;
  smr_pkg::size_t   top_q, top_d, bot_q, bot_d, left_q, left_d, right_q, right_d;
  logic [1:0]       dir_q, dir_d;
  smr_pkg::total_t  issue_cnt_q;
  logic             issue, issue_final;

  logic             rd_pending_q, rd_final_q;
  logic             out_valid_q;
  smr_pkg::elem_t   out_value_q;
  logic             out_final_q;
  smr_pkg::elem_t   rdata;
  logic [AddrW-1:0] load_addr, walk_addr;

  // Effective sizes, saturated into 1..MAX.
  always_comb begin
    if (row_count_q == '0) begin
      rows_eff = smr_pkg::size_t'(1);
    end else if (int'(row_count_q) > MAX_ROWS) begin
      rows_eff = smr_pkg::size_t'(MAX_ROWS);
    end else begin
      rows_eff = row_count_q;
    end
    if (column_count_q == '0) begin
      cols_eff = smr_pkg::size_t'(1);
    end else if (int'(column_count_q) > MAX_COLS) begin
      cols_eff = smr_pkg::size_t'(MAX_COLS);
    end else begin
      cols_eff = column_count_q;
    end
  end

  assign total    = smr_pkg::total_t'(rows_eff) * smr_pkg::total_t'(cols_eff);
  assign last_pos = total - smr_pkg::total_t'(1);
  // A count left beyond a shrunken matrix lands on its last element.
  assign pos = ({1'b0, load_count_q} > last_pos) ? last_pos : {1'b0, load_count_q};
  assign pos_inc    = pos + smr_pkg::total_t'(1);
  assign count_next = pos_inc[smr_pkg::COUNT_W-1:0];
  assign completes  = (pos == last_pos);

  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle) && !in_valid_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;
  assign out_accept  = out_valid_q && !out_stall_i;

  assign issue = (state_q == StWalk) && !rd_pending_q && (!out_valid_q || !out_stall_i);
  assign issue_final = (issue_cnt_q == last_pos);

  assign load_addr = AddrW'(int'(load_row_q) * MAX_COLS + int'(load_col_q));
  assign walk_addr = AddrW'(int'(walk_row_q) * MAX_COLS + int'(walk_col_q));

  // One restoring division step: load row = count / columns, load column = count % columns.
  assign rem_sh       = {div_rem_q, div_dvd_q[smr_pkg::COUNT_W-1]};
  assign rem_sub      = rem_sh - {1'b0, cols_eff};
  assign rem_ge       = (rem_sh >= {1'b0, cols_eff});
  assign div_rem_next = rem_ge ? rem_sub[smr_pkg::SIZE_W-1:0] : rem_sh[smr_pkg::SIZE_W-1:0];
  assign div_dvd_next = {div_dvd_q[smr_pkg::COUNT_W-2:0], rem_ge};

  // Load pointer and sequencer.
  always_comb begin
    state_d      = state_q;
    load_count_d = load_count_q;
    load_row_d   = load_row_q;
    load_col_d   = load_col_q;
    case (state_q)
      StIdle: begin
        if (in_accept) begin
          if (completes) begin
            load_count_d = '0;
            load_row_d   = '0;
            load_col_d   = '0;
            state_d      = StWalk;
          end else begin
            load_count_d = count_next;
            if (count_next == '0) begin
              load_row_d = '0;
              load_col_d = '0;
            end else if (load_col_q == cols_eff - smr_pkg::size_t'(1)) begin
              load_col_d = '0;
              load_row_d = load_row_q + smr_pkg::size_t'(1);
            end else begin
              load_col_d = load_col_q + smr_pkg::size_t'(1);
            end
          end
        end else if (cfg_accept) begin
          state_d = StPrep;
        end
      end
      StPrep: begin
        state_d = StDiv;
      end
      StDiv: begin
        if (div_cnt_q == DivLast) begin
          load_row_d = div_dvd_next[smr_pkg::SIZE_W-1:0];
          load_col_d = div_rem_next;
          state_d    = StIdle;
        end
      end
      StWalk: begin
        if (issue && issue_final) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Next spiral position: follow the ring and turn at its corners.
  always_comb begin
    walk_row_d = walk_row_q;
    walk_col_d = walk_col_q;
    top_d      = top_q;
    bot_d      = bot_q;
    left_d     = left_q;
    right_d    = right_q;
    dir_d      = dir_q;
    case (dir_q)
      DirRight: begin
        if (walk_col_q != right_q) begin
          walk_col_d = walk_col_q + smr_pkg::size_t'(1);
        end else begin
          top_d      = top_q + smr_pkg::size_t'(1);
          walk_row_d = walk_row_q + smr_pkg::size_t'(1);
          dir_d      = DirDown;
        end
      end
      DirDown: begin
        if (walk_row_q != bot_q) begin
          walk_row_d = walk_row_q + smr_pkg::size_t'(1);
        end else begin
          right_d    = right_q - smr_pkg::size_t'(1);
          walk_col_d = walk_col_q - smr_pkg::size_t'(1);
          dir_d      = DirLeft;
        end
      end
      DirLeft: begin
        if (walk_col_q != left_q) begin
          walk_col_d = walk_col_q - smr_pkg::size_t'(1);
        end else begin
          bot_d      = bot_q - smr_pkg::size_t'(1);
          walk_row_d = walk_row_q - smr_pkg::size_t'(1);
          dir_d      = DirUp;
        end
      end
      DirUp: begin
        if (walk_row_q != top_q) begin
          walk_row_d = walk_row_q - smr_pkg::size_t'(1);
        end else begin
          left_d     = left_q + smr_pkg::size_t'(1);
          walk_col_d = walk_col_q + smr_pkg::size_t'(1);
          dir_d      = DirRight;
        end
      end
      default: begin
        dir_d = DirRight;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      row_count_q    <= smr_pkg::SIZE_RESET;
      column_count_q <= smr_pkg::SIZE_RESET;
      load_count_q   <= '0;
      load_row_q     <= '0;
      load_col_q     <= '0;
      issue_cnt_q    <= '0;
      rd_pending_q   <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      load_count_q <= load_count_d;
      load_row_q   <= load_row_d;
      load_col_q   <= load_col_d;
      if (cfg_accept) begin
        case (cfg_index_i)
          smr_pkg::REG_ROW_COUNT:    row_count_q    <= cfg_data_i;
          smr_pkg::REG_COLUMN_COUNT: column_count_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_accept && completes) begin
        issue_cnt_q <= '0;
      end else if (issue) begin
        issue_cnt_q <= issue_cnt_q + smr_pkg::total_t'(1);
      end
      rd_pending_q <= issue;
      if (rd_pending_q) begin
        out_valid_q <= 1'b1;
      end else if (out_accept) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StPrep) begin
      div_cnt_q <= '0;
      div_rem_q <= '0;
      div_dvd_q <= pos[smr_pkg::COUNT_W-1:0];
    end else if (state_q == StDiv) begin
      div_cnt_q <= div_cnt_q + DivCntW'(1);
      div_rem_q <= div_rem_next;
      div_dvd_q <= div_dvd_next;
    end
    if (in_accept && completes) begin
      walk_row_q <= '0;
      walk_col_q <= '0;
      top_q      <= '0;
      left_q     <= '0;
      bot_q      <= rows_eff - smr_pkg::size_t'(1);
      right_q    <= cols_eff - smr_pkg::size_t'(1);
      dir_q      <= DirRight;
    end else if (issue) begin
      walk_row_q <= walk_row_d;
      walk_col_q <= walk_col_d;
      top_q      <= top_d;
      bot_q      <= bot_d;
      left_q     <= left_d;
      right_q    <= right_d;
      dir_q      <= dir_d;
    end
    if (issue) begin
      rd_final_q <= issue_final;
    end
    if (rd_pending_q) begin
      out_value_q <= rdata;
      out_final_q <= rd_final_q;
    end
  end

  smr_ram #(
    .Width(smr_pkg::ELEM_W),
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (in_accept),
    .waddr_i(load_addr),
    .wdata_i(smr_pkg::elem_t'(element_value_i)),
    .re_i   (issue),
    .raddr_i(walk_addr),
    .rdata_o(rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign spiral_value_o = signed'(out_value_q);
  assign final_flag_o   = out_final_q;

  `ASSERT_NEVER(a_read_overrun, clk_i, rst_ni, rd_pending_q && out_valid_q && out_stall_i, "read data arrived while the output register was still full")
  `ASSERT_CLK(a_walk_in_bounds, clk_i, rst_ni, (state_q == StWalk) |-> ((walk_row_q < rows_eff) && (walk_col_q < cols_eff)), "spiral position outside the matrix")
  `ASSERT_CLK(a_walk_count, clk_i, rst_ni, (state_q == StWalk) |-> (issue_cnt_q < total), "spiral walk issued more reads than elements")
  `ASSERT_CLK(a_load_in_bounds, clk_i, rst_ni, (state_q == StIdle) |-> ((load_row_q < rows_eff) && (load_col_q < cols_eff)), "load position outside the matrix")

endmodule

### src/smr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smr_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### tb/sv/spiral_matrix_readout_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spiral matrix readout testbench
// Loads matrices of many shapes element by element and checks every result of
// the clockwise spiral walk against a predictor that keeps its own copy of the
// element store, the load position and both size registers. Both channels are
// throttled at random, and the output is held off long enough to back the
// block up into its input.
// ----------------------------------------------------------------------------
module spiral_matrix_readout_test;

  localparam int MAX_ROWS      = 8;
  localparam int MAX_COLS      = 8;
  localparam int IDLE_PERCENT  = 34;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS  = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;
  localparam int TIMEOUT_NS    = 1_000_000;

  // Indexes past the register list; writes to them must change nothing.
  localparam smr_pkg::cfg_idx_t REG_UNMAPPED_LO = 2'd2;
  localparam smr_pkg::cfg_idx_t REG_UNMAPPED_HI = 2'd3;

  typedef struct packed {
    smr_pkg::elem_t value;
    logic           last;
  } spiral_word_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  smr_pkg::elem_t    element_value_i;
  logic              out_valid_o;
  logic              out_stall_i;
  smr_pkg::elem_t    spiral_value_o;
  logic              final_flag_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  smr_pkg::cfg_idx_t cfg_index_i;
  smr_pkg::size_t    cfg_data_i;

  // Predictor state.
  smr_pkg::elem_t  matrix_store [MAX_ROWS*MAX_COLS];
  smr_pkg::count_t load_pos = '0;
  smr_pkg::size_t  row_size = smr_pkg::SIZE_RESET;
  smr_pkg::size_t  col_size = smr_pkg::SIZE_RESET;
  spiral_word_t    expected_spiral [$];

  int mismatch_count  = 0;
  bit idle_enabled    = 1'b1;
  int hold_off_cycles = 0;

  spiral_matrix_readout #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .element_value_i(element_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .spiral_value_o (spiral_value_o),
    .final_flag_o   (final_flag_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

  function automatic int effective_size(smr_pkg::size_t s, int limit);
    if (s == '0) return 1;
    if (int'(s) > limit) return limit;
    return int'(s);
  endfunction

  function automatic void queue_spiral_word(int r, int c, inout int n, input int total);
    spiral_word_t w;
    w.value = matrix_store[r*MAX_COLS + c];
    w.last  = (n + 1 == total);
    expected_spiral.insert(expected_spiral.size(), w);
    n++;
  endfunction

  // Stores one element and, when it completes the matrix, queues the whole
  // spiral. A load position left beyond a shrunken matrix is pulled back to
  // its last element.
  function automatic void predict_spiral(smr_pkg::elem_t value);
    int rows, cols, total, pos, n, top, bot, lft, rgt;
    rows  = effective_size(row_size, MAX_ROWS);
    cols  = effective_size(col_size, MAX_COLS);
    total = rows * cols;
    pos   = int'(load_pos);
    n     = 0;
    if (pos >= total) pos = total - 1;
    matrix_store[(pos / cols) * MAX_COLS + pos % cols] = value;
    if (pos + 1 < total) begin
      load_pos = smr_pkg::count_t'(pos + 1);
      return;
    end
    load_pos = '0;
    top = 0;
    bot = rows - 1;
    lft = 0;
    rgt = cols - 1;
    while (top <= bot && lft <= rgt) begin
      for (int i = lft; i <= rgt; i++) queue_spiral_word(top, i, n, total);
      top++;
      for (int i = top; i <= bot; i++) queue_spiral_word(i, rgt, n, total);
      rgt--;
      if (top <= bot) begin
        for (int i = rgt; i >= lft; i--) queue_spiral_word(bot, i, n, total);
        bot--;
      end
      if (lft <= rgt) begin
        for (int i = bot; i >= top; i--) queue_spiral_word(i, lft, n, total);
        lft++;
      end
    end
  endfunction

  function automatic void report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
  endfunction

  function automatic smr_pkg::elem_t random_element();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly small sizes, now and then the largest or one outside the range.
  function automatic smr_pkg::size_t random_size();
    case ($urandom_range(9))
      0: return smr_pkg::size_t'($urandom_range(15));
      1: return 4'd8;
      default: return smr_pkg::size_t'($urandom_range(1, 4));
    endcase
  endfunction

  // Results are retired before elements are predicted, since a result taken
  // at the same edge always belongs to an earlier matrix.
  always @(posedge clk_i) begin : check_spiral
    spiral_word_t want;
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        if (expected_spiral.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h last %b",
                                    spiral_value_o, final_flag_o));
        end else begin
          want = expected_spiral.pop_front();
          if (spiral_value_o !== want.value)
            report_mismatch($sformatf("spiral_value expected %h got %h",
                                      want.value, spiral_value_o));
          if (final_flag_o !== want.last)
            report_mismatch($sformatf("final_flag expected %b got %b",
                                      want.last, final_flag_o));
        end
      end
      if (in_valid_i === 1'b1 && in_stall_o === 1'b0) predict_spiral(element_value_i);
    end
  end

  // Output throttle; a requested hold-off is counted down here cycle by cycle.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_off_cycles--;
      end else if (idle_enabled) begin
        out_stall_i <= ($urandom_range(99) < IDLE_PERCENT);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_element(smr_pkg::elem_t value);
    while (idle_enabled && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    element_value_i <= value;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load_elements(int count);
    repeat (count) send_element(random_element());
  endtask

  // Waits for every queued result and then lets the block run dry.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (expected_spiral.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(smr_pkg::cfg_idx_t index, smr_pkg::size_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    if (index == smr_pkg::REG_ROW_COUNT) row_size = data;
    else if (index == smr_pkg::REG_COLUMN_COUNT) col_size = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_matrix_size(smr_pkg::size_t rows, smr_pkg::size_t cols);
    write_register(smr_pkg::REG_ROW_COUNT, rows);
    write_register(smr_pkg::REG_COLUMN_COUNT, cols);
  endtask

  // The registers keep their reset value here, so this is a full 8 x 8
  // matrix. It also fills every entry of the store, which the later size
  // changes in the middle of a load rely on.
  task automatic test_reset_sizes();
    send_element(32'h8000_0000);
    for (int k = 1; k < MAX_ROWS*MAX_COLS - 1; k++) send_element(random_element());
    send_element(32'h7FFF_FFFF);
    settle_block();
  endtask

  // Single element, single row and single column, the last two reached
  // through sizes that saturate.
  task automatic test_thin_shapes();
    set_matrix_size(4'd1, 4'd1);
    send_element(32'hFFFF_FFFF);
    settle_block();
    set_matrix_size(4'd0, 4'd9);
    for (int k = 0; k < MAX_COLS; k++) send_element(32'hAAAA_AAA0 + k);
    settle_block();
    set_matrix_size(4'd15, 4'd0);
    for (int k = 0; k < MAX_ROWS; k++) send_element(32'h5555_5550 + k);
    settle_block();
  endtask

  // A 2 x 3 matrix, then writes to unmapped indexes, which must leave the
  // size alone for the second matrix.
  task automatic test_unmapped_index();
    set_matrix_size(4'd2, 4'd3);
    for (int k = 1; k <= 6; k++) send_element(smr_pkg::elem_t'(k));
    settle_block();
    write_register(REG_UNMAPPED_LO, 4'hF);
    write_register(REG_UNMAPPED_HI, 4'h0);
    for (int k = 1; k <= 6; k++) send_element(-smr_pkg::elem_t'(k));
    settle_block();
  endtask

  task automatic test_resize_mid_load();
    // Shrinking below the elements already loaded: the next one ends the matrix.
    set_matrix_size(4'd2, 4'd4);
    load_elements(5);
    settle_block();
    write_register(smr_pkg::REG_COLUMN_COUNT, 4'd2);
    load_elements(1);
    settle_block();
    // Growing keeps the count and the load simply goes on.
    set_matrix_size(4'd3, 4'd3);
    load_elements(4);
    settle_block();
    write_register(smr_pkg::REG_ROW_COUNT, 4'd5);
    load_elements(11);
    settle_block();
  endtask

  task automatic test_back_to_back();
    idle_enabled = 1'b0;
    set_matrix_size(4'd4, 4'd4);
    load_elements(32);
    settle_block();
    set_matrix_size(4'd1, 4'd1);
    load_elements(3);
    settle_block();
    idle_enabled = 1'b1;
  endtask

  // The output is held while two 4 x 4 matrices are offered, so the walk of
  // the first one blocks the input for a long stretch.
  task automatic test_output_hold();
    set_matrix_size(4'd4, 4'd4);
    idle_enabled    = 1'b0;
    hold_off_cycles = HOLD_CYCLES;
    load_elements(32);
    settle_block();
    idle_enabled = 1'b1;
  endtask

  task automatic test_random_matrices();
    int sent, total, partial, remain;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(3) == 0)
        write_register($urandom_range(1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
                       smr_pkg::size_t'($urandom_range(15)));
      set_matrix_size(random_size(), random_size());
      total = effective_size(row_size, MAX_ROWS) * effective_size(col_size, MAX_COLS);
      if ($urandom_range(4) == 0) begin
        // Stop part way, resize, then finish the matrix under the new size.
        partial = $urandom_range(total - 1);
        load_elements(partial);
        settle_block();
        set_matrix_size(random_size(), random_size());
        total  = effective_size(row_size, MAX_ROWS) * effective_size(col_size, MAX_COLS);
        remain = (total > int'(load_pos)) ? total - int'(load_pos) : 1;
        load_elements(remain);
        sent += partial + remain;
      end else begin
        repeat ($urandom_range(1, 3)) begin
          load_elements(total);
          sent += total;
        end
      end
      settle_block();
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    element_value_i = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = smr_pkg::REG_ROW_COUNT;
    cfg_data_i      = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_sizes();
    test_thin_shapes();
    test_unmapped_index();
    test_resize_mid_load();
    test_back_to_back();
    test_output_hold();
    test_random_matrices();

    settle_block();
    if (mismatch_count == 0 && expected_spiral.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
